// ===== hw/rtl/abkf_pkg.sv =====
// Package for the angle and gyro bias Kalman filter unit.
// Holds fixed field widths, register indexes, reset values and sequencer op codes.
// No dependencies.
`timescale 1ns / 1ps

package abkf_pkg;

  // Fixed field widths of the stream and configuration ports.
  localparam int unsigned ValW   = 32;
  localparam int unsigned NoiseW = 24;
  localparam int unsigned Frac   = 24;
  localparam int unsigned InW    = 88;
  localparam int unsigned OutW   = 96;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_Q_ANGLE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_Q_BIAS  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_R_MEAS  = 2'd2;

  // Reset values of the noise registers (Q0.24).
  localparam logic [NoiseW-1:0] Q_ANGLE_RST = 24'd16777;
  localparam logic [NoiseW-1:0] Q_BIAS_RST  = 24'd50332;
  localparam logic [NoiseW-1:0] R_MEAS_RST  = 24'd503316;

  // Sequencer operations, run in this order for every request.
  localparam int unsigned OpW = 4;
  localparam logic [OpW-1:0] OP_DT_OMEGA = 4'd0;
  localparam logic [OpW-1:0] OP_DT_P11   = 4'd1;
  localparam logic [OpW-1:0] OP_DT_INNER = 4'd2;
  localparam logic [OpW-1:0] OP_QB_DT    = 4'd3;
  localparam logic [OpW-1:0] OP_DIV_K0   = 4'd4;
  localparam logic [OpW-1:0] OP_DIV_K1   = 4'd5;
  localparam logic [OpW-1:0] OP_K0_Y     = 4'd6;
  localparam logic [OpW-1:0] OP_K1_Y     = 4'd7;
  localparam logic [OpW-1:0] OP_K1_P00   = 4'd8;
  localparam logic [OpW-1:0] OP_K1_P01   = 4'd9;
  localparam logic [OpW-1:0] OP_K0_P00   = 4'd10;
  localparam logic [OpW-1:0] OP_K0_P01   = 4'd11;

endpackage

// ===== hw/rtl/angle_bias_kalman_filter_unit.sv =====
// Each request is computed by one shared shift-and-add multiplier and restoring
// divider, which retires one bit per cycle over ten products and two
// quotients. The block takes a new request while the previous result still
// waits on the output side; it is otherwise busy until the update finishes.
// Values are signed Q16.16, covariances signed Q8.24, noise settings Q0.24.
// Top level of the angle and gyro bias Kalman filter; uses abkf_pkg.
`timescale 1ns / 1ps

module angle_bias_kalman_filter_unit #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [abkf_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [abkf_pkg::NoiseW-1:0]       cfg_data_i,
  // Request stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // angle_measured[31:0], rate_measured[63:32], time_step[87:64]
  input  logic [abkf_pkg::InW-1:0]          s_axis_tdata,
  // Result stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // filtered_angle[31:0], estimated_bias[63:32], corrected_rate[95:64]
  output logic [abkf_pkg::OutW-1:0]         m_axis_tdata
);

  localparam int unsigned W   = DATA_WIDTH;
  localparam int unsigned EW  = ((W > 32) ? W : 32) + 4;
  localparam int unsigned NB  = W + abkf_pkg::Frac;
  localparam int unsigned CW  = $clog2(NB + 1);

  localparam logic signed [EW-1:0] SAT_HI = EW'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam logic signed [EW-1:0] SAT_LO = EW'(-(64'sd1 <<< (W - 1)));
  localparam logic signed [EW-1:0] S32_HI = EW'(64'sd2147483647);
  localparam logic signed [EW-1:0] S32_LO = EW'(-64'sd2147483648);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_RUN  = 3'd2;
  localparam logic [2:0] ST_WB   = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  // Saturate a wide intermediate to the state width.
  function automatic logic signed [W-1:0] sat_w(input logic signed [EW-1:0] x);
    logic signed [EW-1:0] r;
    r = x;
    if (x > SAT_HI) r = SAT_HI;
    if (x < SAT_LO) r = SAT_LO;
    return r[W-1:0];
  endfunction

  // Saturate a wide intermediate to a 32-bit output field.
  function automatic logic [31:0] sat_32(input logic signed [EW-1:0] x);
    logic signed [EW-1:0] r;
    r = x;
    if (x > S32_HI) r = S32_HI;
    if (x < S32_LO) r = S32_LO;
    return r[31:0];
  endfunction

  // Magnitude of a signed intermediate.
  function automatic logic [EW-1:0] mag(input logic signed [EW-1:0] x);
    return x[EW-1] ? EW'(-x) : EW'(x);
  endfunction

  logic [2:0] state_q, state_d;
  logic [abkf_pkg::OpW-1:0] op_q;
  logic [CW-1:0] cnt_q;

  logic [abkf_pkg::NoiseW-1:0] qa_q, qb_q, rm_noise_q;
  logic signed [W-1:0] ang_q, bias_q, p00_q, p01_q, p10_q, p11_q;
  logic signed [W-1:0] omega_q, k0_q, k1_q;
  logic signed [EW-1:0] inner_q, s_q, y_q;
  logic signed [31:0] am_q;
  logic [abkf_pkg::NoiseW-1:0] dt_q;

  // Shared arithmetic unit: serial multiplier and restoring divider.
  logic is_div_q, neg_q;
  logic [EW-1:0] hi_q, lo_q, b_q;
  logic [W:0] rem_q, d_q;
  logic [NB-1:0] nq_q;

  logic m_valid_q;
  logic [abkf_pkg::OutW-1:0] m_data_q;

  logic signed [EW-1:0] opa, opb, res;
  logic op_div;
  logic [EW-1:0] amag, bmag;

  logic signed [EW-1:0] dt_e, qa_e, qb_e, rn_e;
  assign dt_e = $signed({{(EW - abkf_pkg::NoiseW){1'b0}}, dt_q});
  assign qa_e = $signed({{(EW - abkf_pkg::NoiseW){1'b0}}, qa_q});
  assign qb_e = $signed({{(EW - abkf_pkg::NoiseW){1'b0}}, qb_q});
  assign rn_e = $signed({{(EW - abkf_pkg::NoiseW){1'b0}}, rm_noise_q});

  // Operand selection for the current operation.
  always_comb begin
    opa = '0;
    opb = '0;
    op_div = 1'b0;
    case (op_q)
      abkf_pkg::OP_DT_OMEGA: begin opa = dt_e;          opb = EW'(omega_q); end
      abkf_pkg::OP_DT_P11:   begin opa = dt_e;          opb = EW'(p11_q);   end
      abkf_pkg::OP_DT_INNER: begin opa = dt_e;          opb = inner_q;      end
      abkf_pkg::OP_QB_DT:    begin opa = qb_e;          opb = dt_e;         end
      abkf_pkg::OP_DIV_K0:   begin opa = EW'(p00_q);    opb = s_q; op_div = 1'b1; end
      abkf_pkg::OP_DIV_K1:   begin opa = EW'(p10_q);    opb = s_q; op_div = 1'b1; end
      abkf_pkg::OP_K0_Y:     begin opa = EW'(k0_q);     opb = y_q;          end
      abkf_pkg::OP_K1_Y:     begin opa = EW'(k1_q);     opb = y_q;          end
      abkf_pkg::OP_K1_P00:   begin opa = EW'(k1_q);     opb = EW'(p00_q);   end
      abkf_pkg::OP_K1_P01:   begin opa = EW'(k1_q);     opb = EW'(p01_q);   end
      abkf_pkg::OP_K0_P00:   begin opa = EW'(k0_q);     opb = EW'(p00_q);   end
      abkf_pkg::OP_K0_P01:   begin opa = EW'(k0_q);     opb = EW'(p01_q);   end
      default:               begin opa = '0;            opb = '0;           end
    endcase
  end

  assign amag = mag(opa);
  assign bmag = mag(opb);

  // Rounded product or clamped quotient, with sign applied.
  logic [2*EW:0]      rnd;
  logic [2*EW-24:0]   msh;
  logic [EW-1:0]      mc, qc;
  always_comb begin
    rnd = {1'b0, hi_q, lo_q} + ((2*EW+1)'(1) << (abkf_pkg::Frac - 1));
    msh = rnd[2*EW:abkf_pkg::Frac];
    mc  = (|msh[2*EW-24:EW-2]) ? (EW'(1) << (EW - 2)) : msh[EW-1:0];
    qc  = (nq_q > (NB'(1) << (W - 1))) ? (EW'(1) << (W - 1)) : EW'(nq_q);
    if (is_div_q) begin
      if (d_q == '0) res = '0;
      else res = neg_q ? -$signed(qc) : $signed(qc);
    end else begin
      res = neg_q ? -$signed(mc) : $signed(mc);
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (s_axis_tvalid) state_d = ST_LOAD;
      ST_LOAD: state_d = ST_RUN;
      ST_RUN:  if (cnt_q == CW'(1)) state_d = ST_WB;
      ST_WB:   state_d = (op_q == abkf_pkg::OP_K0_P01) ? ST_DONE : ST_LOAD;
      ST_DONE: if (!m_valid_q || m_axis_tready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers and output handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      op_q       <= abkf_pkg::OP_DT_OMEGA;
      cnt_q      <= '0;
      m_valid_q  <= 1'b0;
      qa_q       <= abkf_pkg::Q_ANGLE_RST;
      qb_q       <= abkf_pkg::Q_BIAS_RST;
      rm_noise_q <= abkf_pkg::R_MEAS_RST;
      ang_q      <= '0;
      bias_q     <= '0;
      p00_q      <= '0;
      p01_q      <= '0;
      p10_q      <= '0;
      p11_q      <= '0;
    end else begin
      state_q <= state_d;

      // A finished update fills the output register once it is free.
      if (state_q == ST_DONE && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      // Configuration writes; an unknown index is dropped.
      if (cfg_we_i) begin
        case (cfg_index_i)
          abkf_pkg::REG_Q_ANGLE: qa_q       <= cfg_data_i;
          abkf_pkg::REG_Q_BIAS:  qb_q       <= cfg_data_i;
          abkf_pkg::REG_R_MEAS:  rm_noise_q <= cfg_data_i;
          default: ;
        endcase
      end

      case (state_q)
        ST_IDLE: begin
          op_q <= abkf_pkg::OP_DT_OMEGA;
        end
        ST_LOAD: begin
          cnt_q <= op_div ? CW'(NB) : CW'(EW);
        end
        ST_RUN: begin
          cnt_q <= cnt_q - CW'(1);
        end
        ST_WB: begin
          if (op_q != abkf_pkg::OP_K0_P01) op_q <= op_q + abkf_pkg::OpW'(1);
          case (op_q)
            abkf_pkg::OP_DT_OMEGA: ang_q <= sat_w(EW'(ang_q) + res);
            abkf_pkg::OP_DT_P11: begin
              p01_q <= sat_w(EW'(p01_q) - res);
              p10_q <= sat_w(EW'(p10_q) - res);
            end
            abkf_pkg::OP_DT_INNER: p00_q <= sat_w(EW'(p00_q) + res);
            abkf_pkg::OP_QB_DT:    p11_q <= sat_w(EW'(p11_q) + res);
            abkf_pkg::OP_K0_Y:     ang_q <= sat_w(EW'(ang_q) + res);
            abkf_pkg::OP_K1_Y:     bias_q <= sat_w(EW'(bias_q) + res);
            abkf_pkg::OP_K1_P00:   p10_q <= sat_w(EW'(p10_q) - res);
            abkf_pkg::OP_K1_P01:   p11_q <= sat_w(EW'(p11_q) - res);
            abkf_pkg::OP_K0_P00:   p00_q <= sat_w(EW'(p00_q) - res);
            abkf_pkg::OP_K0_P01:   p01_q <= sat_w(EW'(p01_q) - res);
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Payload registers: request capture, temporaries and the arithmetic unit.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid) begin
      am_q    <= s_axis_tdata[31:0];
      dt_q    <= s_axis_tdata[87:64];
      omega_q <= sat_w(EW'($signed(s_axis_tdata[63:32])) - EW'(bias_q));
    end

    if (state_q == ST_LOAD) begin
      is_div_q <= op_div;
      neg_q    <= opa[EW-1] ^ opb[EW-1];
      hi_q     <= '0;
      lo_q     <= amag;
      b_q      <= bmag;
      rem_q    <= '0;
      d_q      <= bmag[W:0];
      nq_q     <= {amag[W-1:0], {abkf_pkg::Frac{1'b0}}};
    end

    // One bit per cycle: shift-add for products, restoring step for quotients.
    if (state_q == ST_RUN) begin
      if (is_div_q) begin
        logic [W+1:0] rn;
        rn = {rem_q, nq_q[NB-1]};
        if (rn >= {1'b0, d_q}) begin
          rem_q <= (W+1)'(rn - {1'b0, d_q});
          nq_q  <= {nq_q[NB-2:0], 1'b1};
        end else begin
          rem_q <= rn[W:0];
          nq_q  <= {nq_q[NB-2:0], 1'b0};
        end
      end else begin
        logic [EW:0] sum;
        sum = lo_q[0] ? ({1'b0, hi_q} + {1'b0, b_q}) : {1'b0, hi_q};
        hi_q <= sum[EW:1];
        lo_q <= {sum[0], lo_q[EW-1:1]};
      end
    end

    // Temporaries that follow some of the writebacks.
    if (state_q == ST_WB) begin
      case (op_q)
        abkf_pkg::OP_DT_P11: inner_q <= res - EW'(p01_q) - EW'(p10_q) + qa_e;
        abkf_pkg::OP_QB_DT:  s_q     <= EW'(p00_q) + rn_e;
        abkf_pkg::OP_DIV_K0: k0_q    <= sat_w(res);
        abkf_pkg::OP_DIV_K1: begin
          k1_q <= sat_w(res);
          y_q  <= EW'(am_q) - EW'(ang_q);
        end
        default: ;
      endcase
    end

    if (state_q == ST_DONE && (!m_valid_q || m_axis_tready)) begin
      m_data_q <= {sat_32(EW'(omega_q)), sat_32(EW'(bias_q)), sat_32(EW'(ang_q))};
    end
  end

`ifndef NO_ASSERTIONS
  // A result only appears at the end of an update.
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result raised outside the done state");

  // The shared unit never runs with an exhausted bit counter.
  a_cnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (cnt_q != '0))
    else $error("arithmetic unit running with zero count");

  // The op index never passes the last operation.
  a_op_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_q <= abkf_pkg::OP_K0_P01))
    else $error("sequencer op index out of range");

  // An accepted request starts the first operation next cycle.
  a_accept_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q == ST_LOAD && op_q == abkf_pkg::OP_DT_OMEGA))
    else $error("accepted request did not start the sequencer");
`endif

endmodule
